FILE: hdl/mlfqs_pkg.sv
// shared types and constants of the mlfq process scheduler
package mlfqs_pkg;

  // command codes of an input transaction
  localparam logic [1:0] CMD_ADMIT    = 2'd0;
  localparam logic [1:0] CMD_DISPATCH = 2'd1;
  localparam logic [1:0] CMD_REPORT   = 2'd2;

  // configuration register indexes
  localparam logic [2:0] CFG_Q_HIGH = 3'd0;
  localparam logic [2:0] CFG_Q_MED  = 3'd1;
  localparam logic [2:0] CFG_Q_LOW  = 3'd2;
  localparam logic [2:0] CFG_BLOCK  = 3'd3;
  localparam logic [2:0] CFG_LAUNCH = 3'd4;

  localparam logic [29:0] RST_Q_HIGH = 30'd10000000;
  localparam logic [29:0] RST_Q_MED  = 30'd20000000;
  localparam logic [29:0] RST_Q_LOW  = 30'd40000000;
  localparam logic [7:0]  RST_BLOCK  = 8'd1;
  localparam logic [29:0] RST_LAUNCH = 30'd10000000;

  localparam logic [30:0] NS_PER_SEC = 31'd1000000000;

  typedef enum logic [1:0] {
    STS_OK, STS_FULL, STS_EMPTY, STS_NO_DISP
  } status_t;

  typedef enum logic [2:0] {
    OC_NONE, OC_DEMOTE, OC_BLOCK, OC_TERM, OC_UNBLOCK
  } outcome_t;

  typedef enum logic [1:0] {
    LV_HIGH, LV_MED, LV_LOW, LV_WAIT
  } level_t;

  typedef enum logic [4:0] {
    OP_NOP, OP_LATCH, OP_SCAN_FREE, OP_SCAN_ID, OP_SCAN_REL, OP_ADD_LAUNCH,
    OP_ADD_MAG, OP_NORM, OP_ADMIT, OP_RD_HEADS, OP_KEY_WAIT, OP_DECIDE,
    OP_POP, OP_PUSH, OP_SET_REL, OP_TERM, OP_FINISH
  } dp_op_t;

  typedef struct packed {
    dp_op_t   op;
    level_t   lvl;
    status_t  sts;
    outcome_t outc;
  } dp_cmd_t;

  typedef struct packed {
    logic   pend_ok;
    logic   wait_nonempty;
    logic   disp_found;
    logic   scan_done;
    logic   scan_hit;
    logic   neg;
    logic   mag_ge_grant;
    level_t pend_level;
  } dp_sts_t;

  typedef enum logic [3:0] {
    S_IDLE, S_SCAN_FREE, S_ADD, S_NORM1, S_NORM2, S_ADMIT, S_RD, S_WKEY,
    S_SCAN_ID, S_DECIDE, S_POP, S_BRANCH, S_PUSHW, S_SCAN_REL, S_TERM, S_FINISH
  } state_t;

endpackage

FILE: hdl/mlfq_process_scheduler_unit.sv
// admit, dispatch and report time is bounded by the slot table scan (one entry a cycle)
// throughput: one transaction at a time; the next is taken once the result is registered
// result waits in an output register while the next transaction is taken
// reset: rst_n synchronous active low, queues empty, table free, clock zero, defaults
module mlfq_process_scheduler_unit
  import mlfqs_pkg::*;
#(
  parameter int PROCESS_SLOTS = 32,
  parameter int ID_BITS       = 22
) (
  input  logic               clk,
  input  logic               rst_n,
  // input transaction channel
  input  logic               in_valid,
  output logic               in_stall,
  input  logic [1:0]         in_cmd,
  input  logic [21:0]        in_proc_id,
  input  logic signed [30:0] in_ran_ns,
  // result transaction channel
  output logic               out_valid,
  input  logic               out_stall,
  output logic [1:0]         out_status,
  output logic [2:0]         out_outcome,
  output logic [21:0]        out_chosen_id,
  output logic [29:0]        out_grant_ns,
  output logic [1:0]         out_source_level,
  output logic [31:0]        out_clock_sec,
  output logic [29:0]        out_clock_nsec,
  output logic [5:0]         out_live_count,
  // configuration write channel
  input  logic               cfg_valid,
  output logic               cfg_ready,
  input  logic [2:0]         cfg_index,
  input  logic [29:0]        cfg_data
);

  dp_cmd_t dp_cmd;
  dp_sts_t dp_sts;

  // registers are always writable; writes must only come while idle, which the block does not enforce
  assign cfg_ready = 1'b1;

  // controller: steps each transaction through scan, clock and queue phases
  mlfqs_ctrl u_ctrl (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_stall  (in_stall),
    .in_cmd    (in_cmd),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .cmd_o     (dp_cmd),
    .sts_i     (dp_sts)
  );

  // datapath: four queue memories, slot table, clock and result register
  mlfqs_dp #(
    .PROCESS_SLOTS (PROCESS_SLOTS),
    .ID_BITS       (ID_BITS)
  ) u_dp (
    .clk              (clk),
    .rst_n            (rst_n),
    .cmd_i            (dp_cmd),
    .sts_o            (dp_sts),
    .in_cmd           (in_cmd),
    .in_proc_id       (in_proc_id),
    .in_ran_ns        (in_ran_ns),
    .cfg_we           (cfg_valid && cfg_ready),
    .cfg_index        (cfg_index),
    .cfg_data         (cfg_data),
    .out_status       (out_status),
    .out_outcome      (out_outcome),
    .out_chosen_id    (out_chosen_id),
    .out_grant_ns     (out_grant_ns),
    .out_source_level (out_source_level),
    .out_clock_sec    (out_clock_sec),
    .out_clock_nsec   (out_clock_nsec),
    .out_live_count   (out_live_count)
  );

endmodule

FILE: hdl/mlfqs_ctrl.sv
// sequencing state machine of the mlfq process scheduler
module mlfqs_ctrl
  import mlfqs_pkg::*;
(
  input  logic       clk,
  input  logic       rst_n,
  input  logic       in_valid,
  output logic       in_stall,
  input  logic [1:0] in_cmd,
  output logic       out_valid,
  input  logic       out_stall,
  output dp_cmd_t    cmd_o,
  input  dp_sts_t    sts_i
);

  state_t   state_r, state_nxt;
  logic [1:0] kind_r, kind_nxt;
  status_t  sts_r, sts_nxt;
  outcome_t outc_r, outc_nxt;
  logic     out_valid_r, out_valid_nxt;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      kind_r      <= CMD_ADMIT;
      sts_r       <= STS_OK;
      outc_r      <= OC_NONE;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      kind_r      <= kind_nxt;
      sts_r       <= sts_nxt;
      outc_r      <= outc_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  always_comb begin
    state_nxt     = state_r;
    kind_nxt      = kind_r;
    sts_nxt       = sts_r;
    outc_nxt      = outc_r;
    out_valid_nxt = out_valid_r && out_stall;
    cmd_o.op      = OP_NOP;
    cmd_o.lvl     = LV_HIGH;
    cmd_o.sts     = sts_r;
    cmd_o.outc    = outc_r;
    in_stall      = (state_r != S_IDLE);
    case (state_r)
      S_IDLE: begin
        if (in_valid) begin
          cmd_o.op = OP_LATCH;
          kind_nxt = in_cmd;
          sts_nxt  = STS_OK;
          outc_nxt = OC_NONE;
          case (in_cmd)
            CMD_ADMIT:    state_nxt = S_SCAN_FREE;
            CMD_DISPATCH: state_nxt = S_RD;
            default: begin
              if (sts_i.pend_ok) begin
                state_nxt = S_ADD;
              end else begin
                sts_nxt   = STS_NO_DISP;
                state_nxt = S_FINISH;
              end
            end
          endcase
        end
      end
      S_SCAN_FREE: begin
        cmd_o.op = OP_SCAN_FREE;
        if (sts_i.scan_done) begin
          if (sts_i.scan_hit) begin
            state_nxt = S_ADD;
          end else begin
            sts_nxt   = STS_FULL;
            state_nxt = S_FINISH;
          end
        end
      end
      S_ADD: begin
        cmd_o.op  = (kind_r == CMD_ADMIT) ? OP_ADD_LAUNCH : OP_ADD_MAG;
        state_nxt = S_NORM1;
      end
      S_NORM1: begin
        cmd_o.op  = OP_NORM;
        state_nxt = S_NORM2;
      end
      S_NORM2: begin
        cmd_o.op  = OP_NORM;
        state_nxt = (kind_r == CMD_ADMIT) ? S_ADMIT : S_RD;
      end
      S_ADMIT: begin
        cmd_o.op  = OP_ADMIT;
        state_nxt = S_FINISH;
      end
      S_RD: begin
        cmd_o.op = OP_RD_HEADS;
        if (kind_r == CMD_DISPATCH) begin
          state_nxt = sts_i.wait_nonempty ? S_WKEY : S_DECIDE;
        end else begin
          state_nxt = S_POP;
        end
      end
      S_WKEY: begin
        cmd_o.op  = OP_KEY_WAIT;
        state_nxt = S_SCAN_ID;
      end
      S_SCAN_ID: begin
        cmd_o.op = OP_SCAN_ID;
        if (sts_i.scan_done) begin
          state_nxt = (kind_r == CMD_DISPATCH) ? S_DECIDE : S_TERM;
        end
      end
      S_DECIDE: begin
        cmd_o.op = OP_DECIDE;
        if (!sts_i.disp_found) sts_nxt = STS_EMPTY;
        state_nxt = S_FINISH;
      end
      S_POP: begin
        cmd_o.op  = OP_POP;
        state_nxt = S_BRANCH;
      end
      S_BRANCH: begin
        if (sts_i.pend_level == LV_WAIT) begin
          cmd_o.op  = OP_PUSH;
          cmd_o.lvl = LV_HIGH;
          outc_nxt  = OC_UNBLOCK;
          state_nxt = S_FINISH;
        end else if (sts_i.neg) begin
          outc_nxt  = OC_TERM;
          state_nxt = S_SCAN_ID;
        end else if (sts_i.mag_ge_grant) begin
          cmd_o.op  = OP_PUSH;
          cmd_o.lvl = (sts_i.pend_level == LV_HIGH) ? LV_MED : LV_LOW;
          outc_nxt  = OC_DEMOTE;
          state_nxt = S_FINISH;
        end else begin
          cmd_o.op  = OP_SET_REL;
          outc_nxt  = OC_BLOCK;
          state_nxt = S_PUSHW;
        end
      end
      S_PUSHW: begin
        cmd_o.op  = OP_PUSH;
        cmd_o.lvl = LV_WAIT;
        state_nxt = S_SCAN_REL;
      end
      S_SCAN_REL: begin
        cmd_o.op = OP_SCAN_REL;
        if (sts_i.scan_done) state_nxt = S_FINISH;
      end
      S_TERM: begin
        cmd_o.op  = OP_TERM;
        state_nxt = S_FINISH;
      end
      S_FINISH: begin
        if (!out_valid_r || !out_stall) begin
          cmd_o.op      = OP_FINISH;
          out_valid_nxt = 1'b1;
          state_nxt     = S_IDLE;
        end
      end
      default: state_nxt = S_IDLE;
    endcase
  end

  assign out_valid = out_valid_r;

endmodule

FILE: hdl/mlfqs_dp.sv
// datapath of the mlfq process scheduler: queues, slot table, clock, result
module mlfqs_dp
  import mlfqs_pkg::*;
#(
  parameter int PROCESS_SLOTS = 32,
  parameter int ID_BITS       = 22
) (
  input  logic               clk,
  input  logic               rst_n,
  input  dp_cmd_t            cmd_i,
  output dp_sts_t            sts_o,
  input  logic [1:0]         in_cmd,
  input  logic [21:0]        in_proc_id,
  input  logic signed [30:0] in_ran_ns,
  input  logic               cfg_we,
  input  logic [2:0]         cfg_index,
  input  logic [29:0]        cfg_data,
  output logic [1:0]         out_status,
  output logic [2:0]         out_outcome,
  output logic [21:0]        out_chosen_id,
  output logic [29:0]        out_grant_ns,
  output logic [1:0]         out_source_level,
  output logic [31:0]        out_clock_sec,
  output logic [29:0]        out_clock_nsec,
  output logic [5:0]         out_live_count
);

  localparam int N  = PROCESS_SLOTS;
  localparam int IW = $clog2(N);
  localparam int CW = $clog2(N + 1);
  localparam logic [CW-1:0] N_C  = CW'(N);
  localparam logic [IW-1:0] LAST = IW'(N - 1);
  localparam logic [21:0] ID_MASK = 22'((64'd1 << ID_BITS) - 64'd1);

  // configuration
  logic [29:0] qh_r, qm_r, ql_r, li_r;
  logic [7:0]  bs_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      qh_r <= RST_Q_HIGH;
      qm_r <= RST_Q_MED;
      ql_r <= RST_Q_LOW;
      bs_r <= RST_BLOCK;
      li_r <= RST_LAUNCH;
    end else if (cfg_we) begin
      case (cfg_index)
        CFG_Q_HIGH: qh_r <= cfg_data;
        CFG_Q_MED:  qm_r <= cfg_data;
        CFG_Q_LOW:  ql_r <= cfg_data;
        CFG_BLOCK:  bs_r <= cfg_data[7:0];
        CFG_LAUNCH: li_r <= cfg_data;
        default: ;
      endcase
    end
  end

  logic [21:0] key_r, res_id_r;
  logic [30:0] raw_r, mag;
  logic [29:0] res_grant_r;
  level_t      res_lvl_r;
  logic [31:0] sec_r, rel_r;
  logic [30:0] ns_r;
  logic        pv_r;
  level_t      pl_r;
  logic [29:0] pg_r;
  logic [CW-1:0] live_r;
  logic [N-1:0]  used_r;

  assign mag = raw_r[30] ? (~raw_r + 31'd1) : raw_r;

  // queue lanes: high, middle, low, blocked
  logic [3:0][21:0] hq;
  logic [3:0]       cnt_nz;

  for (genvar l = 0; l < 4; l++) begin : g_lane
    logic [21:0]   mem [N];
    logic [IW-1:0] head_r, tail_r;
    logic [CW-1:0] cnt_r;
    logic [21:0]   hq_r;
    logic          push_me, pop_me;

    assign push_me = ((cmd_i.op == OP_PUSH) && (cmd_i.lvl == level_t'(2'(l)))) ||
                     ((cmd_i.op == OP_ADMIT) && (l == 0));
    assign pop_me  = (cmd_i.op == OP_POP) && (pl_r == level_t'(2'(l)));

    always_ff @(posedge clk) begin
      if (push_me && (cnt_r != N_C)) mem[tail_r] <= key_r;
      if (cmd_i.op == OP_RD_HEADS) hq_r <= mem[head_r];
    end

    always_ff @(posedge clk) begin
      if (!rst_n) begin
        head_r <= '0;
        tail_r <= '0;
        cnt_r  <= '0;
      end else if (push_me && (cnt_r != N_C)) begin
        tail_r <= (tail_r == LAST) ? '0 : tail_r + 1'b1;
        cnt_r  <= cnt_r + 1'b1;
      end else if (pop_me) begin
        head_r <= (head_r == LAST) ? '0 : head_r + 1'b1;
        cnt_r  <= cnt_r - 1'b1;
      end
    end

    assign hq[l]     = hq_r;
    assign cnt_nz[l] = (cnt_r != '0);
  end

  // slot table scan, one entry a cycle, registered memory reads
  logic [21:0]   id_mem  [N];
  logic [31:0]   rel_mem [N];
  logic [21:0]   id_rd_r;
  logic [31:0]   rel_rd_r;
  logic [CW-1:0] sc_idx_r;
  logic          sc_pend_r, sc_hit_r;
  logic [IW-1:0] sc_pidx_r, sc_hidx_r;
  logic [31:0]   sc_hrel_r;
  logic          idx_lt, rd_en, match;
  logic [IW-1:0] sidx;

  assign idx_lt = (sc_idx_r < N_C);
  assign sidx   = sc_idx_r[IW-1:0];
  assign rd_en  = (((cmd_i.op == OP_SCAN_ID) && !sc_hit_r) || (cmd_i.op == OP_SCAN_REL))
                  && idx_lt;
  assign match  = sc_pend_r && used_r[sc_pidx_r] && (id_rd_r == key_r);

  always_ff @(posedge clk) begin
    if (rd_en) begin
      id_rd_r  <= id_mem[sidx];
      rel_rd_r <= rel_mem[sidx];
    end
    if (cmd_i.op == OP_ADMIT) begin
      id_mem[sc_hidx_r]  <= key_r;
      rel_mem[sc_hidx_r] <= '0;
    end else if ((cmd_i.op == OP_SCAN_REL) && match) begin
      rel_mem[sc_pidx_r] <= rel_r;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      sc_idx_r  <= '0;
      sc_pend_r <= 1'b0;
      sc_hit_r  <= 1'b0;
    end else begin
      case (cmd_i.op)
        OP_LATCH: begin
          sc_idx_r  <= '0;
          sc_pend_r <= 1'b0;
          sc_hit_r  <= 1'b0;
        end
        OP_SCAN_FREE: begin
          if (!sc_hit_r && idx_lt) begin
            if (!used_r[sidx]) begin
              sc_hit_r  <= 1'b1;
              sc_hidx_r <= sidx;
            end
            sc_idx_r <= sc_idx_r + 1'b1;
          end
        end
        OP_SCAN_ID, OP_SCAN_REL: begin
          sc_pend_r <= rd_en;
          if (rd_en) begin
            sc_pidx_r <= sidx;
            sc_idx_r  <= sc_idx_r + 1'b1;
          end
          if ((cmd_i.op == OP_SCAN_ID) && match && !sc_hit_r) begin
            sc_hit_r  <= 1'b1;
            sc_hidx_r <= sc_pidx_r;
            sc_hrel_r <= rel_rd_r;
          end
        end
        default: ;
      endcase
    end
  end

  // dispatch choice
  logic        found_rdy, released, take_wait, disp_found;
  level_t      rlv, dlv;
  logic [29:0] q;
  logic [21:0] did;

  always_comb begin
    found_rdy = |cnt_nz[2:0];
    if (cnt_nz[0]) begin
      rlv = LV_HIGH; q = qh_r;
    end else if (cnt_nz[1]) begin
      rlv = LV_MED;  q = qm_r;
    end else if (cnt_nz[2]) begin
      rlv = LV_LOW;  q = ql_r;
    end else begin
      rlv = LV_HIGH; q = qh_r;
    end
    released   = !sc_hit_r || (sec_r >= sc_hrel_r);
    take_wait  = cnt_nz[3] && (released || !found_rdy);
    dlv        = take_wait ? LV_WAIT : rlv;
    did        = hq[dlv];
    disp_found = found_rdy || cnt_nz[3];
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      sec_r  <= '0;
      ns_r   <= '0;
      pv_r   <= 1'b0;
      pl_r   <= LV_HIGH;
      pg_r   <= '0;
      live_r <= '0;
      used_r <= '0;
    end else begin
      case (cmd_i.op)
        OP_ADD_LAUNCH: ns_r <= ns_r + {1'b0, li_r};
        OP_ADD_MAG:    ns_r <= ns_r + mag;
        OP_NORM: begin
          if (ns_r >= NS_PER_SEC) begin
            ns_r  <= ns_r - NS_PER_SEC;
            sec_r <= sec_r + 32'd1;
          end
        end
        OP_ADMIT: begin
          used_r[sc_hidx_r] <= 1'b1;
          live_r <= live_r + 1'b1;
        end
        OP_TERM: begin
          if (sc_hit_r) used_r[sc_hidx_r] <= 1'b0;
          if (live_r != '0) live_r <= live_r - 1'b1;
        end
        OP_DECIDE: begin
          pv_r <= disp_found;
          if (disp_found) begin
            pl_r <= dlv;
            pg_r <= q;
          end
        end
        OP_POP: pv_r <= 1'b0;
        default: ;
      endcase
    end
  end

  logic [CW+5:0] live_ext;
  assign live_ext = {6'b0, live_r};

  always_ff @(posedge clk) begin
    case (cmd_i.op)
      OP_LATCH: begin
        raw_r       <= in_ran_ns;
        key_r       <= in_proc_id & ID_MASK;
        res_id_r    <= (in_cmd == CMD_ADMIT) ? (in_proc_id & ID_MASK) : '0;
        res_grant_r <= '0;
        res_lvl_r   <= LV_HIGH;
      end
      OP_KEY_WAIT: key_r <= hq[3];
      OP_DECIDE: begin
        if (disp_found) begin
          res_id_r    <= did;
          res_grant_r <= q;
          res_lvl_r   <= dlv;
        end
      end
      OP_POP: begin
        key_r       <= hq[pl_r];
        res_id_r    <= hq[pl_r];
        res_grant_r <= pg_r;
        res_lvl_r   <= pl_r;
      end
      OP_SET_REL: rel_r <= sec_r + {24'b0, bs_r};
      OP_FINISH: begin
        out_status       <= cmd_i.sts;
        out_outcome      <= cmd_i.outc;
        out_chosen_id    <= res_id_r;
        out_grant_ns     <= res_grant_r;
        out_source_level <= res_lvl_r;
        out_clock_sec    <= sec_r;
        out_clock_nsec   <= ns_r[29:0];
        out_live_count   <= live_ext[5:0];
      end
      default: ;
    endcase
  end

  assign sts_o.pend_ok       = pv_r && cnt_nz[pl_r];
  assign sts_o.wait_nonempty = cnt_nz[3];
  assign sts_o.disp_found    = disp_found;
  assign sts_o.scan_done     = sc_hit_r || ((sc_idx_r == N_C) && !sc_pend_r);
  assign sts_o.scan_hit      = sc_hit_r;
  assign sts_o.neg           = raw_r[30];
  assign sts_o.mag_ge_grant  = (mag >= {1'b0, pg_r});
  assign sts_o.pend_level    = pl_r;

endmodule

FILE: hdl/mlfqs_checker.sv
// port checker of the mlfq process scheduler and its bind
module mlfqs_checker
  import mlfqs_pkg::*;
(
  input logic        clk,
  input logic        rst_n,
  input logic        out_valid,
  input logic        out_stall,
  input logic [1:0]  out_status,
  input logic [2:0]  out_outcome,
  input logic [31:0] out_clock_sec,
  input logic [29:0] out_clock_nsec
);

  a_hold_valid: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_stall |=> out_valid)
    else $error("result dropped while stalled");

  a_hold_sec: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_stall |=> $stable(out_clock_sec))
    else $error("stalled result changed");

  a_nsec_range: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> out_clock_nsec < 30'd1000000000)
    else $error("clock nanoseconds not normalized");

  a_err_no_outcome: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && (out_status != STS_OK) |-> out_outcome == OC_NONE)
    else $error("error result with an outcome");

  a_reset_idle: assert property (@(posedge clk)
    !rst_n |=> !out_valid)
    else $error("result valid after reset");

endmodule

bind mlfq_process_scheduler_unit mlfqs_checker u_mlfqs_checker (
  .clk            (clk),
  .rst_n          (rst_n),
  .out_valid      (out_valid),
  .out_stall      (out_stall),
  .out_status     (out_status),
  .out_outcome    (out_outcome),
  .out_clock_sec  (out_clock_sec),
  .out_clock_nsec (out_clock_nsec)
);
